[rtl/tpd_pkg.sv]
package tpd_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_MAP_TASKS    = 64;
    localparam int DEF_MAX_REDUCE_TASKS = 16;
    localparam int DEF_TICK_WIDTH       = 32;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 6;
    localparam int KIND_W     = 2;
    localparam int MAP_CNT_W  = 7;
    localparam int RED_CNT_W  = 5;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [MAP_CNT_W-1:0] MAP_CNT_RST = 7'd0;
    localparam logic [RED_CNT_W-1:0] RED_CNT_RST = 5'd4;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

    // grant kind codes
    localparam logic [KIND_W-1:0] GRANT_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] GRANT_MAP    = 2'd1;
    localparam logic [KIND_W-1:0] GRANT_REDUCE = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ASK    = 2'd1,
        OP_SUBMIT = 2'd2
    } tpd_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } tpd_state_t;

    typedef struct packed {
        logic assigned;
        logic completed;
    } tpd_flags_t;

    // update applied to the entry leaving the head of a chain
    typedef struct packed {
        logic set_assigned;
        logic set_completed;
    } tpd_head_ctl_t;

endpackage

[rtl/tpd_cell.sv]
module tpd_cell #(
    parameter int TICK_WIDTH = tpd_pkg::DEF_TICK_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  tpd_pkg::tpd_flags_t    in_flags,
    input  logic [TICK_WIDTH-1:0]  in_start,
    output tpd_pkg::tpd_flags_t    flags,
    output logic [TICK_WIDTH-1:0]  start
);
    import tpd_pkg::*;

    tpd_flags_t            flags_reg;
    logic [TICK_WIDTH-1:0] start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (shift_en) begin
            flags_reg <= in_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            start_reg <= in_start;
        end
    end

    assign flags = flags_reg;
    assign start = start_reg;

endmodule

[rtl/tpd_chain.sv]
module tpd_chain #(
    parameter int DEPTH      = tpd_pkg::DEF_MAX_MAP_TASKS,
    parameter int TICK_WIDTH = tpd_pkg::DEF_TICK_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  tpd_pkg::tpd_head_ctl_t head_ctl,
    input  logic [TICK_WIDTH-1:0]  stamp_tick,
    output tpd_pkg::tpd_flags_t    head_flags,
    output logic [TICK_WIDTH-1:0]  head_start
);
    import tpd_pkg::*;

    tpd_flags_t            cell_flags [DEPTH];
    logic [TICK_WIDTH-1:0] cell_start [DEPTH];
    tpd_flags_t            feed_flags [DEPTH];
    logic [TICK_WIDTH-1:0] feed_start [DEPTH];
    tpd_flags_t            ring_flags;
    logic [TICK_WIDTH-1:0] ring_start;

    // head entry, updated on its way back to the tail
    always_comb begin
        ring_flags = cell_flags[0];
        ring_start = cell_start[0];
        if (head_ctl.set_assigned) begin
            ring_flags.assigned = 1'b1;
            ring_start          = stamp_tick;
        end
        if (head_ctl.set_completed) begin
            ring_flags.completed = 1'b1;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign feed_flags[i] = ring_flags;
            assign feed_start[i] = ring_start;
        end else begin : g_body
            assign feed_flags[i] = cell_flags[i+1];
            assign feed_start[i] = cell_start[i+1];
        end

        tpd_cell #(
            .TICK_WIDTH(TICK_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift_en(shift_en),
            .in_flags(feed_flags[i]),
            .in_start(feed_start[i]),
            .flags   (cell_flags[i]),
            .start   (cell_start[i])
        );
    end

    assign head_flags = cell_flags[0];
    assign head_start = cell_start[0];

endmodule

[rtl/two_phase_task_dispatcher.sv]
// tick and unused op words give a registered result in the cycle after accept
// ask and submit words rotate the whole chosen task chain once in the scan state, then
// pass the finish state; an ask with nothing left goes straight to the finish state
// throughput: one word at a time, set by the single head comparator of the rotating chain
// reset: synchronous, active low; clears task flags, totals, tick and done flag at once,
// loads the registers with 0 map tasks, 4 reduce tasks and a timeout of 30
module two_phase_task_dispatcher #(
    parameter int MAX_MAP_TASKS    = tpd_pkg::DEF_MAX_MAP_TASKS,
    parameter int MAX_REDUCE_TASKS = tpd_pkg::DEF_MAX_REDUCE_TASKS,
    parameter int TICK_WIDTH       = tpd_pkg::DEF_TICK_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tpd_pkg::OP_W-1:0]       s_op,
    input  logic                           s_submit_kind,
    input  logic [tpd_pkg::IDX_W-1:0]      s_submit_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_granted,
    output logic [tpd_pkg::KIND_W-1:0]     m_grant_kind,
    output logic [tpd_pkg::IDX_W-1:0]      m_grant_index,
    output logic                           m_submit_ok,
    output logic                           m_all_done,
    input  logic                           cfg_we,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tpd_pkg::*;

    localparam int MAX_DEPTH = (MAX_MAP_TASKS > MAX_REDUCE_TASKS) ? MAX_MAP_TASKS
                                                                   : MAX_REDUCE_TASKS;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > MAP_CNT_W) ? CNT_W : MAP_CNT_W;
    localparam int AGE_W     = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;
    localparam int MAP_SAT   = (MAX_MAP_TASKS > 127) ? 127 : MAX_MAP_TASKS;
    localparam int RED_SAT   = (MAX_REDUCE_TASKS > 31) ? 31 : MAX_REDUCE_TASKS;
    localparam logic [CNT_W-1:0] MAP_LAST = CNT_W'(MAX_MAP_TASKS - 1);
    localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(MAX_REDUCE_TASKS - 1);

    tpd_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   phase_reg, phase_next;       // 0 map chain, 1 reduce chain
    logic                   is_ask_reg, is_ask_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   ok_reg, ok_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       grant_idx_reg, grant_idx_next;
    logic [MAP_CNT_W-1:0]   map_count_reg, map_count_next;
    logic [RED_CNT_W-1:0]   red_count_reg, red_count_next;
    logic [TIMEOUT_W-1:0]   timeout_reg, timeout_next;
    logic [MAP_CNT_W-1:0]   map_total_reg, map_total_next;
    logic [RED_CNT_W-1:0]   red_total_reg, red_total_next;
    logic [TICK_WIDTH-1:0]  tick_reg, tick_next;
    logic                   job_reg, job_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_granted_reg, m_granted_next;
    logic [KIND_W-1:0]      m_grant_kind_reg, m_grant_kind_next;
    logic [IDX_W-1:0]       m_grant_index_reg, m_grant_index_next;
    logic                   m_submit_ok_reg, m_submit_ok_next;
    logic                   m_all_done_reg, m_all_done_next;

    tpd_flags_t             map_head_flags, red_head_flags, head_flags;
    logic [TICK_WIDTH-1:0]  map_head_start, red_head_start, head_start;
    tpd_head_ctl_t          head_ctl, map_ctl, red_ctl;
    logic                   shift_en;

    logic [CMP_W-1:0]       cnt_ext, count_sel_ext;
    logic [TICK_WIDTH-1:0]  age;
    logic                   in_use, expired, eligible, submit_hit, last;
    logic                   out_free;
    logic [MAP_CNT_W-1:0]   cfg_map_val;
    logic [RED_CNT_W-1:0]   cfg_red_val;
    logic                   finish_now;

    // head entry of the chain being rotated
    always_comb begin
        head_flags    = phase_reg ? red_head_flags : map_head_flags;
        head_start    = phase_reg ? red_head_start : map_head_start;
        cnt_ext       = CMP_W'(cnt_reg);
        count_sel_ext = phase_reg ? CMP_W'(red_count_reg) : CMP_W'(map_count_reg);
        in_use        = cnt_ext < count_sel_ext;
        age           = tick_reg - head_start;
        expired       = AGE_W'(age) > AGE_W'(timeout_reg);
        eligible      = in_use && !head_flags.completed &&
                        (!head_flags.assigned || expired);
        submit_hit    = cnt_ext == CMP_W'(idx_reg);
        last          = cnt_reg == (phase_reg ? RED_LAST : MAP_LAST);
        cfg_map_val   = cfg_wdata[MAP_CNT_W-1:0];
        cfg_red_val   = cfg_wdata[RED_CNT_W-1:0];
        finish_now    = (map_total_reg >= map_count_reg) &&
                        (red_total_reg >= red_count_reg);
        out_free      = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            map_count_reg <= MAP_CNT_RST;
            red_count_reg <= RED_CNT_RST;
            timeout_reg   <= TIMEOUT_RST;
            map_total_reg <= '0;
            red_total_reg <= '0;
            tick_reg      <= '0;
            job_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            map_count_reg <= map_count_next;
            red_count_reg <= red_count_next;
            timeout_reg   <= timeout_next;
            map_total_reg <= map_total_next;
            red_total_reg <= red_total_next;
            tick_reg      <= tick_next;
            job_reg       <= job_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg           <= cnt_next;
        phase_reg         <= phase_next;
        is_ask_reg        <= is_ask_next;
        idx_reg           <= idx_next;
        ok_reg            <= ok_next;
        found_reg         <= found_next;
        grant_idx_reg     <= grant_idx_next;
        m_granted_reg     <= m_granted_next;
        m_grant_kind_reg  <= m_grant_kind_next;
        m_grant_index_reg <= m_grant_index_next;
        m_submit_ok_reg   <= m_submit_ok_next;
        m_all_done_reg    <= m_all_done_next;
    end

    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        phase_next         = phase_reg;
        is_ask_next        = is_ask_reg;
        idx_next           = idx_reg;
        ok_next            = ok_reg;
        found_next         = found_reg;
        grant_idx_next     = grant_idx_reg;
        map_count_next     = map_count_reg;
        red_count_next     = red_count_reg;
        timeout_next       = timeout_reg;
        map_total_next     = map_total_reg;
        red_total_next     = red_total_reg;
        tick_next          = tick_reg;
        job_next           = job_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_granted_next     = m_granted_reg;
        m_grant_kind_next  = m_grant_kind_reg;
        m_grant_index_next = m_grant_index_reg;
        m_submit_ok_next   = m_submit_ok_reg;
        m_all_done_next    = m_all_done_reg;
        head_ctl           = '0;
        shift_en           = 1'b0;
        s_ready            = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAP_COUNT: begin
                    map_count_next = (cfg_map_val > MAP_CNT_W'(MAP_SAT)) ?
                                     MAP_CNT_W'(MAP_SAT) : cfg_map_val;
                end
                CFG_REDUCE_COUNT: begin
                    red_count_next = (cfg_red_val > RED_CNT_W'(RED_SAT)) ?
                                     RED_CNT_W'(RED_SAT) : cfg_red_val;
                end
                CFG_TIMEOUT: begin
                    timeout_next = cfg_wdata[TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    grant_idx_next = '0;
                    ok_next        = 1'b0;
                    unique case (s_op)
                        OP_TICK: begin
                            tick_next          = tick_reg + 1'b1;
                            m_valid_next       = 1'b1;
                            m_granted_next     = 1'b0;
                            m_grant_kind_next  = GRANT_NONE;
                            m_grant_index_next = '0;
                            m_submit_ok_next   = 1'b0;
                            m_all_done_next    = job_reg;
                        end
                        OP_ASK: begin
                            is_ask_next = 1'b1;
                            if (map_total_reg < map_count_reg) begin
                                phase_next = 1'b0;
                                state_next = ST_SCAN;
                            end else if (red_total_reg < red_count_reg) begin
                                phase_next = 1'b1;
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_FIN;
                            end
                        end
                        OP_SUBMIT: begin
                            is_ask_next = 1'b0;
                            phase_next  = s_submit_kind;
                            idx_next    = s_submit_index;
                            ok_next     = s_submit_kind ?
                                          (MAP_CNT_W'(s_submit_index) < MAP_CNT_W'(red_count_reg)) :
                                          (MAP_CNT_W'(s_submit_index) < map_count_reg);
                            state_next  = ST_SCAN;
                        end
                        default: begin
                            m_valid_next       = 1'b1;
                            m_granted_next     = 1'b0;
                            m_grant_kind_next  = GRANT_NONE;
                            m_grant_index_next = '0;
                            m_submit_ok_next   = 1'b0;
                            m_all_done_next    = job_reg;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                shift_en = 1'b1;
                if (is_ask_reg) begin
                    // first eligible entry to pass the head wins
                    if (eligible && !found_reg) begin
                        head_ctl.set_assigned = 1'b1;
                        found_next            = 1'b1;
                        grant_idx_next        = cnt_ext[IDX_W-1:0];
                    end
                end else if (submit_hit && ok_reg) begin
                    head_ctl.set_completed = 1'b1;
                    if (!head_flags.completed) begin
                        if (phase_reg) begin
                            red_total_next = red_total_reg + 1'b1;
                        end else begin
                            map_total_next = map_total_reg + 1'b1;
                        end
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!is_ask_reg && finish_now) begin
                    job_next = 1'b1;
                end
                m_valid_next       = 1'b1;
                m_granted_next     = is_ask_reg && found_reg;
                m_grant_kind_next  = !(is_ask_reg && found_reg) ? GRANT_NONE :
                                     (phase_reg ? GRANT_REDUCE : GRANT_MAP);
                m_grant_index_next = (is_ask_reg && found_reg) ? grant_idx_reg : '0;
                m_submit_ok_next   = !is_ask_reg && ok_reg;
                m_all_done_next    = job_reg || (!is_ask_reg && finish_now);
                state_next         = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign map_ctl = phase_reg ? '0 : head_ctl;
    assign red_ctl = phase_reg ? head_ctl : '0;

    tpd_chain #(
        .DEPTH     (MAX_MAP_TASKS),
        .TICK_WIDTH(TICK_WIDTH)
    ) u_map_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (shift_en && !phase_reg),
        .head_ctl  (map_ctl),
        .stamp_tick(tick_reg),
        .head_flags(map_head_flags),
        .head_start(map_head_start)
    );

    tpd_chain #(
        .DEPTH     (MAX_REDUCE_TASKS),
        .TICK_WIDTH(TICK_WIDTH)
    ) u_red_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (shift_en && phase_reg),
        .head_ctl  (red_ctl),
        .stamp_tick(tick_reg),
        .head_flags(red_head_flags),
        .head_start(red_head_start)
    );

    assign m_valid       = m_valid_reg;
    assign m_granted     = m_granted_reg;
    assign m_grant_kind  = m_grant_kind_reg;
    assign m_grant_index = m_grant_index_reg;
    assign m_submit_ok   = m_submit_ok_reg;
    assign m_all_done    = m_all_done_reg;

endmodule

[rtl/tpd_checker.sv]
module tpd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_granted,
    input logic [tpd_pkg::KIND_W-1:0] m_grant_kind,
    input logic [tpd_pkg::IDX_W-1:0]  m_grant_index,
    input logic                       m_submit_ok,
    input logic                       m_all_done
);
    import tpd_pkg::*;

    // no new word taken while a result is stuck
    a_no_accept_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result blocked");

    // result stays until taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before taken");

    // done flag never falls once shown
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_all_done) |=> (!m_valid || m_all_done))
        else $error("all_done cleared");

    // grant fields agree with granted
    a_grant_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_granted) |-> (m_grant_kind == GRANT_NONE && m_grant_index == '0))
        else $error("grant fields set without a grant");

    // a word is either a grant or a submit, never both
    a_grant_vs_submit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_granted && m_submit_ok))
        else $error("grant and submit_ok both set");

endmodule

bind two_phase_task_dispatcher tpd_checker u_tpd_checker (.*);

[bench/two_phase_task_dispatcher_checker.sv]
`timescale 1ns / 100ps

module two_phase_task_dispatcher_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [tpd_pkg::OP_W-1:0]       s_op,
    input  logic                           s_submit_kind,
    input  logic [tpd_pkg::IDX_W-1:0]      s_submit_index,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_granted,
    input  logic [tpd_pkg::KIND_W-1:0]     m_grant_kind,
    input  logic [tpd_pkg::IDX_W-1:0]      m_grant_index,
    input  logic                           m_submit_ok,
    input  logic                           m_all_done,
    input  logic                           cfg_we,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import tpd_pkg::*;

    typedef struct packed {
        logic              granted;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        logic              ok;
        logic              done;
    } dispatch_word_t;

    // row 0 holds the map tasks, row 1 the reduce tasks
    bit                        slot_asg   [0:1][0:DEF_MAX_MAP_TASKS-1];
    bit                        slot_done  [0:1][0:DEF_MAX_MAP_TASKS-1];
    logic [DEF_TICK_WIDTH-1:0] slot_stamp [0:1][0:DEF_MAX_MAP_TASKS-1];
    int unsigned               done_total [0:1];
    int unsigned               slot_count [0:1];
    logic [TIMEOUT_W-1:0]      timeout;
    logic [DEF_TICK_WIDTH-1:0] now_tick;
    bit                        job_done;

    dispatch_word_t pending_outcomes[$];
    dispatch_word_t want;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // lowest incomplete task that is free or held past the timeout, stamped on grant
    function automatic int claim_slot(int k);
        logic [DEF_TICK_WIDTH-1:0] age;
        for (int i = 0; i < slot_count[k]; i++) begin
            if (slot_done[k][i])
                continue;
            if (slot_asg[k][i]) begin
                age = now_tick - slot_stamp[k][i];
                if (age <= {{(DEF_TICK_WIDTH-TIMEOUT_W){1'b0}}, timeout})
                    continue;
            end
            slot_asg[k][i]   = 1'b1;
            slot_stamp[k][i] = now_tick;
            return i;
        end
        return -1;
    endfunction

    function automatic dispatch_word_t dispatch_outcome(logic [OP_W-1:0] op, logic kind,
                                                         logic [IDX_W-1:0] idx);
        dispatch_word_t r;
        int             got;
        int             k;
        r = '0;
        case (op)
            OP_TICK: now_tick = now_tick + 1'b1;
            OP_ASK: begin
                // reduce work only once the map phase is fully complete
                k = (done_total[0] < slot_count[0]) ? 0 : 1;
                if (done_total[k] < slot_count[k]) begin
                    got = claim_slot(k);
                    if (got >= 0) begin
                        r.granted = 1'b1;
                        r.kind    = (k == 1) ? GRANT_REDUCE : GRANT_MAP;
                        r.index   = got[IDX_W-1:0];
                    end
                end
            end
            OP_SUBMIT: begin
                if (idx < slot_count[kind]) begin
                    r.ok = 1'b1;
                    if (!slot_done[kind][idx]) begin
                        slot_done[kind][idx] = 1'b1;
                        done_total[kind]++;
                    end
                end
                if (done_total[0] >= slot_count[0] && done_total[1] >= slot_count[1])
                    job_done = 1'b1;
            end
            default: ;
        endcase
        r.done = job_done;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                for (int i = 0; i < DEF_MAX_MAP_TASKS; i++) begin
                    slot_asg[k][i]  = 1'b0;
                    slot_done[k][i] = 1'b0;
                end
                done_total[k] = 0;
            end
            slot_count[0] = MAP_CNT_RST;
            slot_count[1] = RED_CNT_RST;
            timeout       = TIMEOUT_RST;
            now_tick      = '0;
            job_done      = 1'b0;
            pending_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result word with nothing pending, expected none, got %p",
                             $time, {m_granted, m_grant_kind, m_grant_index, m_submit_ok,
                                     m_all_done});
                    mismatches++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("granted", 8'(want.granted), 8'(m_granted));
                    check_field("grant_kind", 8'(want.kind), 8'(m_grant_kind));
                    check_field("grant_index", 8'(want.index), 8'(m_grant_index));
                    check_field("submit_ok", 8'(want.ok), 8'(m_submit_ok));
                    check_field("all_done", 8'(want.done), 8'(m_all_done));
                end
            end
            if (s_valid && s_ready) begin
                want             = dispatch_outcome(s_op, s_submit_kind, s_submit_index);
                pending_outcomes = {pending_outcomes, want};
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAP_COUNT:
                        slot_count[0] = (cfg_wdata[MAP_CNT_W-1:0] > DEF_MAX_MAP_TASKS) ?
                                        DEF_MAX_MAP_TASKS : cfg_wdata[MAP_CNT_W-1:0];
                    CFG_REDUCE_COUNT:
                        slot_count[1] = (cfg_wdata[RED_CNT_W-1:0] > DEF_MAX_REDUCE_TASKS) ?
                                        DEF_MAX_REDUCE_TASKS : cfg_wdata[RED_CNT_W-1:0];
                    CFG_TIMEOUT: timeout = cfg_wdata[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

[bench/two_phase_task_dispatcher_tb.sv]
`timescale 1ns / 100ps

module two_phase_task_dispatcher_tb;
    import tpd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic            KIND_MAP    = 1'b0;
    localparam logic            KIND_REDUCE = 1'b1;
    localparam int              CYCLE_LIMIT = 1_000_000;
    localparam int              PHASES      = 10;
    localparam int              PHASE_WORDS = 200;
    localparam int              HOLD_CYCLES = 300;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op           = OP_TICK;
    logic                  s_submit_kind  = KIND_MAP;
    logic [IDX_W-1:0]      s_submit_index = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b1;
    logic                  m_granted;
    logic [KIND_W-1:0]     m_grant_kind;
    logic [IDX_W-1:0]      m_grant_index;
    logic                  m_submit_ok;
    logic                  m_all_done;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_MAP_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit idle_on     = 1'b1;
    bit hold_go     = 1'b0;
    bit hold_served = 1'b0;

    // task counts in effect, used to aim submits at real tasks
    int unsigned live_count [0:1];
    int unsigned cursor     [0:1] = '{0, 0};

    // per phase register values; out-of-range counts check saturation
    logic [CFG_DATA_W-1:0] map_plan     [0:PHASES-1] = '{1, 4, 10, 16, 0, 24, 40, 127, 64, 50};
    logic [CFG_DATA_W-1:0] reduce_plan  [0:PHASES-1] = '{0, 2, 4, 8, 1, 31, 12, 16, 16, 5};
    logic [CFG_DATA_W-1:0] timeout_plan [0:PHASES-1] =
        '{0, 3, 65535, 1, 2, 6, 12, 30, 4, 65535};

    two_phase_task_dispatcher u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_submit_kind  (s_submit_kind),
        .s_submit_index (s_submit_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted      (m_granted),
        .m_grant_kind   (m_grant_kind),
        .m_grant_index  (m_grant_index),
        .m_submit_ok    (m_submit_ok),
        .m_all_done     (m_all_done),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    two_phase_task_dispatcher_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_submit_kind  (s_submit_kind),
        .s_submit_index (s_submit_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted      (m_granted),
        .m_grant_kind   (m_grant_kind),
        .m_grant_index  (m_grant_index),
        .m_submit_ok    (m_submit_ok),
        .m_all_done     (m_all_done),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: short random stalls plus one long hold-off
    initial begin
        int hold_cnt;
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge aclk);
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic kind,
                             input logic [IDX_W-1:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_submit_kind  <= kind;
        s_submit_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // registers may only change once every result is back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] maps,
                              input logic [CFG_DATA_W-1:0] reduces,
                              input logic [CFG_DATA_W-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAP_COUNT;
        cfg_wdata <= maps;
        @(posedge aclk);
        cfg_index <= CFG_REDUCE_COUNT;
        cfg_wdata <= reduces;
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_we <= 1'b0;
        live_count[0] = (maps[MAP_CNT_W-1:0] > DEF_MAX_MAP_TASKS) ?
                        DEF_MAX_MAP_TASKS : maps[MAP_CNT_W-1:0];
        live_count[1] = (reduces[RED_CNT_W-1:0] > DEF_MAX_REDUCE_TASKS) ?
                        DEF_MAX_REDUCE_TASKS : reduces[RED_CNT_W-1:0];
    endtask

    initial begin
        int               pick;
        logic             kind;
        logic [IDX_W-1:0] idx;
        int unsigned      cnt;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: no map tasks, so an ask goes straight to reduce work
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_UNUSED, KIND_REDUCE, 6'd63);
        send_word(OP_TICK, KIND_MAP, 6'd0);
        send_word(OP_SUBMIT, KIND_REDUCE, 6'd63);
        send_word(OP_SUBMIT, KIND_MAP, 6'd0);
        settle();

        // zero timeout: a task stamped at an earlier tick is free again
        set_config(16'd2, 16'd1, 16'd0);
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_TICK, KIND_MAP, 6'd0);
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_SUBMIT, KIND_MAP, 6'd0);
        send_word(OP_SUBMIT, KIND_MAP, 6'd0);
        send_word(OP_SUBMIT, KIND_MAP, 6'd1);
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_SUBMIT, KIND_REDUCE, 6'd0);
        send_word(OP_SUBMIT, KIND_REDUCE, 6'd1);
        send_word(OP_ASK, KIND_MAP, 6'd0);
        send_word(OP_TICK, KIND_REDUCE, 6'd63);
        send_word(OP_UNUSED, KIND_MAP, 6'd0);
        settle();

        set_config(16'd0, 16'd0, 16'hFFFF);
        send_word(OP_ASK, KIND_REDUCE, 6'd63);
        send_word(OP_SUBMIT, KIND_MAP, 6'd63);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                idle_on = 1'b0;
            set_config(map_plan[p], reduce_plan[p], timeout_plan[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == 40)
                    hold_go = 1'b1;
                pick = $urandom_range(0, 99);
                kind = 1'($urandom_range(0, 1));
                idx  = IDX_W'($urandom_range(0, 63));
                if (pick < 28) begin
                    send_word(OP_TICK, kind, idx);
                end else if (pick < 62) begin
                    send_word(OP_ASK, kind, idx);
                end else if (pick < 94) begin
                    // mostly walk through the tasks in order so phases get finished
                    kind = ($urandom_range(0, 9) < 7) ? KIND_MAP : KIND_REDUCE;
                    cnt  = live_count[kind];
                    if (cnt != 0 && $urandom_range(0, 3) != 0) begin
                        cursor[kind] = cursor[kind] % cnt;
                        idx          = cursor[kind][IDX_W-1:0];
                        cursor[kind] = cursor[kind] + 1;
                    end
                    send_word(OP_SUBMIT, kind, idx);
                end else begin
                    send_word(OP_UNUSED, kind, idx);
                end
            end
            settle();
        end

        repeat (80) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
